@@ hdl/stc_pkg.sv @@
// Shared constants and codes for the subslot timing calculator.
// No dependencies; used by subslot_timing_calc and stc_checker.
package stc_pkg;

  // Default width of slot time values inside the datapath
  localparam int TIME_BITS_DEF = 20;

  // Field widths fixed by the stream format
  localparam int SLOT_W  = 20;
  localparam int NODE_W  = 16;
  localparam int AIR_W   = 16;
  localparam int CNT_W   = 8;
  localparam int GUARD_W = 16;
  localparam int WIN_W   = 20;
  localparam int SUB_W   = 21;
  localparam int START_W = 32;
  localparam int CODE_W  = 3;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_W  = 56;
  localparam int OUT_W = 88;

  // Configuration data and index widths
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Trailing guard is at most a tenth of the slot
  localparam int TRAIL_DIVISOR = 10;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0]   CNT_RST   = 8'd4;
  localparam logic [GUARD_W-1:0] GUARD_RST = 16'd10;
  localparam logic [GUARD_W-1:0] TLIM_RST  = 16'd50;

  typedef enum logic [CODE_W-1:0] {
    FAULT_NONE    = 3'd0,
    FAULT_SETTING = 3'd1,
    FAULT_GUARDS  = 3'd2,
    FAULT_WINDOW  = 3'd3,
    FAULT_OVERRUN = 3'd4
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBSLOT_COUNT = 2'd0,
    REG_GUARD_TIME    = 2'd1,
    REG_TRAIL_LIMIT   = 2'd2
  } cfg_reg_e;

endpackage

@@ hdl/stc_div_cell.sv @@
// One restoring-division cell: a single quotient bit per cycle while en_i is high.
// Depends on nothing; instantiated in a row by stc_div_chain.
module stc_div_cell #(
  parameter int NW = 20,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [PW-1:0] pay_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [NW-1:0] num_d;
  logic [DW-1:0] rem_d;

  // Shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    num_d = {num_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_d;
      rem_o <= rem_d;
      den_o <= den_i;
      pay_o <= pay_i;
    end
  end

endmodule

@@ hdl/stc_div_chain.sv @@
// Row of NW division cells giving quotient and remainder at the last cell.
// Depends on stc_div_cell.
module stc_div_chain #(
  parameter int NW = 20,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] pay_o
);

  logic          v_w   [NW+1];
  logic [NW-1:0] num_w [NW+1];
  logic [DW-1:0] rem_w [NW+1];
  logic [DW-1:0] den_w [NW+1];
  logic [PW-1:0] pay_w [NW+1];

  assign v_w[0]   = valid_i;
  assign num_w[0] = num_i;
  assign rem_w[0] = '0;
  assign den_w[0] = den_i;
  assign pay_w[0] = pay_i;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    stc_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(v_w[g]),
      .num_i  (num_w[g]),
      .rem_i  (rem_w[g]),
      .den_i  (den_w[g]),
      .pay_i  (pay_w[g]),
      .valid_o(v_w[g+1]),
      .num_o  (num_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .den_o  (den_w[g+1]),
      .pay_o  (pay_w[g+1])
    );
  end

  assign valid_o = v_w[NW];
  assign quo_o   = num_w[NW];
  assign rem_o   = rem_w[NW];
  assign pay_o   = pay_w[NW];

endmodule

@@ hdl/subslot_timing_calc.sv @@
// Subslot timing calculator top level: input stage, three division rows, glue
// stages and an output register with skid. Depends on stc_pkg, stc_div_chain.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | slot_length, node_id, airtime
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | timing_ok .. start_offset
//  cfg      | in  | cfg_we_i (always taken)      | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the skid slot is empty; the three rows of
// one-bit division cells make up most of the pipeline depth.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A stalled output fills the skid slot; the pipeline then freezes until the
// skid slot drains, and s_axis_tready stays low while the skid slot is full.
module subslot_timing_calc #(
  parameter int TIME_BITS = stc_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // slot_length[19:0], node_id[35:20], airtime[51:36], zero[55:52]
  input  logic [stc_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // timing_ok[0], fault_code[3:1], sub_pos[11:4], window_length[31:12],
  // subslot_length[52:32], start_offset[84:53], zero[87:85]
  output logic [stc_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import stc_pkg::*;

  localparam int T   = TIME_BITS;
  localparam int SW  = T + 10;
  localparam int CW  = T + 11;
  localparam int PER_W = GUARD_W + 1;
  localparam int GDS_W = CNT_W + GUARD_W;

  // Reciprocal of the trailing divisor, exact for every T-bit slot
  localparam int RCP_SH = T + 4;
  localparam logic [T:0] TRAIL_RCP =
    (T+1)'(((64'd1 << RCP_SH) + 64'(TRAIL_DIVISOR - 1)) / 64'(TRAIL_DIVISOR));

  typedef struct packed {
    logic [T-1:0]       slot;
    logic [NODE_W-1:0]  node;
    logic [AIR_W-1:0]   air;
    logic [CNT_W-1:0]   cnt;
    logic [GUARD_W-1:0] guard;
    logic [GUARD_W-1:0] tlim;
    logic               bad;
    logic [T-1:0]       trail;
    logic [T-1:0]       usable;
    logic [PER_W-1:0]   per;
    logic [CNT_W-1:0]   count;
    logic [GDS_W-1:0]   guards;
    logic               f2;
    logic [CNT_W-1:0]   idx;
    logic [CW-1:0]      gsum;
    logic [T-1:0]       avail;
    logic [T-1:0]       win;
    logic [T:0]         sublen;
    logic [SW-1:0]      prod;
    logic [SW-1:0]      start;
  } ctx_t;

  localparam int PW = $bits(ctx_t);

  // Configuration registers
  logic [CNT_W-1:0]   cnt_q;
  logic [GUARD_W-1:0] guard_q, tlim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= CNT_RST;
      guard_q <= GUARD_RST;
      tlim_q  <= TLIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SUBSLOT_COUNT: cnt_q   <= cfg_data_i[CNT_W-1:0];
        REG_GUARD_TIME:    guard_q <= cfg_data_i;
        REG_TRAIL_LIMIT:   tlim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the skid slot is occupied
  logic en;
  logic skid_v_q;
  assign en = !skid_v_q;
  assign s_axis_tready = en;

  // Stage A: input capture with config snapshot
  logic a_v_q;
  ctx_t a_q, a_d;

  always_comb begin
    a_d       = '0;
    a_d.slot  = T'(s_axis_tdata[SLOT_W-1:0]);
    a_d.node  = s_axis_tdata[SLOT_W +: NODE_W];
    a_d.air   = s_axis_tdata[SLOT_W+NODE_W +: AIR_W];
    a_d.cnt   = cnt_q;
    a_d.guard = guard_q;
    a_d.tlim  = tlim_q;
    a_d.bad   = (cnt_q == '0) || (a_d.slot == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (en) a_v_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en && s_axis_tvalid) a_q <= a_d;
  end

  // Stage B: trailing guard is the lesser of limit and slot/10
  logic b_v_q;
  ctx_t b_q, b_d;
  logic [2*T+3:0] trail_prod;
  logic [T-1:0]   slot_tenth;
  always_comb begin
    trail_prod = (2*T+4)'(a_q.slot) * (2*T+4)'(TRAIL_RCP);
    slot_tenth = trail_prod[RCP_SH +: T];
    b_d = a_q;
    b_d.trail = (T'(b_d.tlim) < slot_tenth) ? T'(b_d.tlim) : slot_tenth;
  end

  // Stage B2: usable time and period per subslot
  logic b2_v_q;
  ctx_t b2_q, b2_d;
  always_comb begin
    b2_d = b_q;
    b2_d.usable = (b_q.slot > b_q.trail) ? b_q.slot - b_q.trail : '0;
    b2_d.per    = PER_W'(b_q.air) + PER_W'(b_q.guard);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q  <= 1'b0;
      b2_v_q <= 1'b0;
    end else if (en) begin
      b_v_q  <= a_v_q;
      b2_v_q <= b_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q  <= b_d;
      b2_q <= b2_d;
    end
  end

  // Row 2: how many periods fit
  logic c2_v;
  logic [T-1:0] c2_q;
  logic [PER_W-1:0] fit_rem_unused;
  logic [PW-1:0] c2_p;
  stc_div_chain #(.NW(T), .DW(PER_W), .PW(PW)) u_div_fit (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b2_v_q), .num_i(b2_q.usable),
    .den_i(b2_q.per), .pay_i(b2_q),
    .valid_o(c2_v), .quo_o(c2_q), .rem_o(fit_rem_unused), .pay_o(c2_p)
  );

  // Stage C: effective subslot count
  logic c_v_q;
  ctx_t c_q, c_d;
  logic [T-1:0] fit;
  always_comb begin
    c_d = c2_p;
    fit = (c2_q == '0) ? T'(1) : c2_q;
    c_d.count = ((c_d.air != '0) && (fit < T'(c_d.cnt))) ? CNT_W'(fit) : c_d.cnt;
  end

  // Stage C2: total of per-subslot guards
  logic c2s_v_q;
  ctx_t c2s_q, c2s_d;
  always_comb begin
    c2s_d = c_q;
    c2s_d.guards = c_q.count * c_q.guard;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q   <= 1'b0;
      c2s_v_q <= 1'b0;
    end else if (en) begin
      c_v_q   <= c2_v;
      c2s_v_q <= c_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= c_d;
      c2s_q <= c2s_d;
    end
  end

  // Row 3: node_id modulo count
  logic c3_v;
  logic [CNT_W-1:0] c3_r;
  logic [NODE_W-1:0] idx_quo_unused;
  logic [PW-1:0] c3_p;
  stc_div_chain #(.NW(NODE_W), .DW(CNT_W), .PW(PW)) u_div_idx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c2s_v_q), .num_i(c2s_q.node),
    .den_i(c2s_q.count), .pay_i(c2s_q),
    .valid_o(c3_v), .quo_o(idx_quo_unused), .rem_o(c3_r), .pay_o(c3_p)
  );

  // Stage D: subslot index, guard overflow, guards plus trailing guard
  logic d_v_q;
  ctx_t d_q, d_d;
  always_comb begin
    d_d = c3_p;
    d_d.idx  = c3_r;
    d_d.f2   = CW'(d_d.guards) >= CW'(d_d.slot);
    d_d.gsum = CW'(d_d.guards) + CW'(d_d.trail);
  end

  // Stage D2: drop trailing guard on a short slot
  logic d2_v_q;
  ctx_t d2_q, d2_d;
  always_comb begin
    d2_d = d_q;
    if (d_q.gsum >= CW'(d_q.slot)) d2_d.trail = '0;
  end

  // Stage D3: time left for windows
  logic d3_v_q;
  ctx_t d3_q, d3_d;
  always_comb begin
    d3_d = d2_q;
    d3_d.avail = d2_q.slot - T'(d2_q.guards) - d2_q.trail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q  <= 1'b0;
      d2_v_q <= 1'b0;
      d3_v_q <= 1'b0;
    end else if (en) begin
      d_v_q  <= c3_v;
      d2_v_q <= d_v_q;
      d3_v_q <= d2_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q  <= d_d;
      d2_q <= d2_d;
      d3_q <= d3_d;
    end
  end

  // Row 4: window per subslot
  logic c4_v;
  logic [T-1:0] c4_q;
  logic [CNT_W-1:0] win_rem_unused;
  logic [PW-1:0] c4_p;
  stc_div_chain #(.NW(T), .DW(CNT_W), .PW(PW)) u_div_win (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d3_v_q), .num_i(d3_q.avail),
    .den_i(d3_q.count), .pay_i(d3_q),
    .valid_o(c4_v), .quo_o(c4_q), .rem_o(win_rem_unused), .pay_o(c4_p)
  );

  // Stage E: window and subslot length
  logic e_v_q;
  ctx_t e_q, e_d;
  always_comb begin
    e_d = c4_p;
    e_d.win    = c4_q;
    e_d.sublen = (T+1)'(c4_q) + (T+1)'(e_d.guard);
  end

  // Stage E2: index times subslot length
  logic e2_v_q;
  ctx_t e2_q, e2_d;
  always_comb begin
    e2_d = e_q;
    e2_d.prod = SW'(e_q.idx) * SW'(e_q.sublen);
  end

  // Stage E3: start offset
  logic e3_v_q;
  ctx_t e3_q, e3_d;
  always_comb begin
    e3_d = e2_q;
    e3_d.start = e2_q.prod + SW'(e2_q.guard);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q  <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
    end else if (en) begin
      e_v_q  <= c4_v;
      e2_v_q <= e_v_q;
      e3_v_q <= e2_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q  <= e_d;
      e2_q <= e2_d;
      e3_q <= e3_d;
    end
  end

  // Result selection: overrun check and fault priority
  logic               over;
  fault_e             code;
  logic               ok;
  logic [CNT_W-1:0]   r_idx;
  logic [WIN_W-1:0]   r_win;
  logic [SUB_W-1:0]   r_sub;
  logic [START_W-1:0] r_start;
  logic [OUT_W-1:0]   res;

  always_comb begin
    over = (e3_q.air != '0) &&
           (CW'(e3_q.start) + CW'(e3_q.air) + CW'(e3_q.trail) > CW'(e3_q.slot));
    ok      = 1'b0;
    code    = FAULT_NONE;
    r_idx   = e3_q.idx;
    r_win   = WIN_W'(e3_q.win);
    r_sub   = SUB_W'(e3_q.sublen);
    r_start = START_W'(e3_q.start);
    if (e3_q.bad) begin
      code = FAULT_SETTING;
      r_idx = '0; r_win = '0; r_sub = '0; r_start = '0;
    end else if (e3_q.f2) begin
      code = FAULT_GUARDS;
      r_win = '0; r_sub = '0; r_start = '0;
    end else if (e3_q.win == '0) begin
      code = FAULT_WINDOW;
      r_start = '0;
    end else if (over) begin
      code = FAULT_OVERRUN;
    end else begin
      ok = 1'b1;
    end
    res = {3'b000, r_start, r_sub, r_win, r_idx, code, ok};
  end

  // Output register with one skid slot
  logic [OUT_W-1:0] out_q, skid_q;
  logic             out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) skid_v_q <= 1'b0;
    end else if (out_v_q && !m_axis_tready) begin
      if (e3_v_q) skid_v_q <= 1'b1;
    end else begin
      out_v_q <= e3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) out_q <= skid_q;
    end else if (out_v_q && !m_axis_tready) begin
      if (e3_v_q) skid_q <= res;
    end else begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ hdl/stc_checker.sv @@
// Port-level checks on the subslot timing calculator result stream.
// Depends on stc_pkg; bound to subslot_timing_calc below.
module stc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [stc_pkg::OUT_W-1:0]  m_axis_tdata
);
  import stc_pkg::*;

  logic [CODE_W-1:0] code;
  assign code = m_axis_tdata[3:1];

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // timing_ok set exactly when no fault
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (code == FAULT_NONE)))
    else $error("timing_ok disagrees with fault code");

  // Bad setting clears every other field
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (code == FAULT_SETTING) |-> (m_axis_tdata[87:4] == '0))
    else $error("bad setting result not cleared");

  // Guard overflow clears window, subslot length and start
  a_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (code == FAULT_GUARDS) |-> (m_axis_tdata[87:12] == '0))
    else $error("guard fault result not cleared");

  // Zero window has zero window length and start
  a_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (code == FAULT_WINDOW) |->
      (m_axis_tdata[31:12] == '0) && (m_axis_tdata[84:53] == '0))
    else $error("zero window result inconsistent");

endmodule

bind subslot_timing_calc stc_checker u_stc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
